@@ rtl/imm_pkg.sv @@
package imm_pkg;

  // widths fixed by the word formats
  localparam int MODE_BITS    = 2;
  localparam int INDEX_BITS   = 4;
  localparam int IN_ELEM_BITS = 16;
  localparam int PRODUCT_BITS = 48;
  localparam int CFG_BITS     = 5;
  localparam int CFG_IDX_BITS = 2;

  // operation codes carried in the mode field
  localparam logic [MODE_BITS-1:0] MODE_WRITE_A = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_WRITE_B = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_QUERY   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_OF_A       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INNER_DIMENSION = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS_OF_B       = 2'd2;

  // input word
  typedef struct packed {
    logic [MODE_BITS-1:0]           mode;
    logic [INDEX_BITS-1:0]          row_index;
    logic [INDEX_BITS-1:0]          col_index;
    logic signed [IN_ELEM_BITS-1:0] element_value;
  } imm_in_t;

  // result word
  typedef struct packed {
    logic signed [PRODUCT_BITS-1:0] product_value;
    logic                           index_error;
  } imm_out_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
  } imm_mac_ctl_t;

endpackage

@@ rtl/integer_matrix_multiply.sv @@
// channel  signals                       direction  word
// in       in_valid/in_ready/in_word     input      imm_in_t (write A, write B, query)
// out      out_valid/out_ready/out_word  output     imm_out_t (one per query)
// cfg      cfg_write_en/cfg_index/data   input      5-bit dimension registers
//
// writes are taken while in_ready is high and never block; a query drops in_ready while it
// reads one pair per cycle, drains the read, multiply and accumulate registers
// and loads the output register, which waits while an unread result holds it.
// a query with an index error skips the walk and drops in_ready until its error word loads.
// reset clears control and sets all dimensions to 16; matrix memories keep no reset.
// a finished result waits in the output register while writes keep flowing in.
module integer_matrix_multiply #(
  parameter int MAX_DIM      = 16,
  parameter int ELEMENT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  imm_pkg::imm_in_t                  in_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output imm_pkg::imm_out_t                 out_word,
  input  logic                              cfg_write_en,
  input  logic [imm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [imm_pkg::CFG_BITS-1:0]      cfg_data
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_TOP = (MAX_DIM > 31) ? 31 : MAX_DIM;
  localparam logic [imm_pkg::CFG_BITS-1:0] DIM_LIMIT = imm_pkg::CFG_BITS'(DIM_TOP);
  localparam logic [imm_pkg::CFG_BITS-1:0] DIM_RESET =
    imm_pkg::CFG_BITS'((16 > DIM_TOP) ? DIM_TOP : 16);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } imm_state_t;

  imm_state_t state, state_next;

  logic [imm_pkg::CFG_BITS-1:0]   rows_of_a, inner_dimension, cols_of_b;
  logic [imm_pkg::CFG_BITS-1:0]   cfg_clamped;
  logic [imm_pkg::CFG_BITS-1:0]   k;
  logic [imm_pkg::INDEX_BITS-1:0] q_row, q_col;
  logic                           q_err;
  logic                           rd_v;
  logic                           in_fire, is_query, query_err;
  logic                           a_wr, b_wr, rd_en, out_load, mac_busy;
  logic [AW-1:0]                  wr_addr, a_rd_addr, b_rd_addr;
  logic [ELEMENT_BITS-1:0]        elem, a_data, b_data;
  logic [imm_pkg::CFG_BITS-1:0]   row_ext, col_ext;
  logic [imm_pkg::PRODUCT_BITS-1:0] acc;
  imm_pkg::imm_mac_ctl_t          mac_ctl;

  // configuration registers, clamped into 1..MAX_DIM, at most 31
  always_comb begin
    priority if (cfg_data == '0) begin
      cfg_clamped = imm_pkg::CFG_BITS'(1);
    end else if (cfg_data > DIM_LIMIT) begin
      cfg_clamped = DIM_LIMIT;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_a       <= DIM_RESET;
      inner_dimension <= DIM_RESET;
      cols_of_b       <= DIM_RESET;
    end else if (cfg_write_en) begin
      if (cfg_index == imm_pkg::REG_ROWS_OF_A)       rows_of_a       <= cfg_clamped;
      if (cfg_index == imm_pkg::REG_INNER_DIMENSION) inner_dimension <= cfg_clamped;
      if (cfg_index == imm_pkg::REG_COLS_OF_B)       cols_of_b       <= cfg_clamped;
    end
  end

  // input decode
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign row_ext   = imm_pkg::CFG_BITS'(in_word.row_index);
  assign col_ext   = imm_pkg::CFG_BITS'(in_word.col_index);
  assign is_query  = in_fire && (in_word.mode == imm_pkg::MODE_QUERY);
  assign query_err = (row_ext >= rows_of_a) || (col_ext >= cols_of_b);
  assign a_wr = in_fire && (in_word.mode == imm_pkg::MODE_WRITE_A) &&
                (row_ext < rows_of_a) && (col_ext < inner_dimension);
  assign b_wr = in_fire && (in_word.mode == imm_pkg::MODE_WRITE_B) &&
                (row_ext < inner_dimension) && (col_ext < cols_of_b);
  assign wr_addr = AW'(int'(in_word.row_index) * MAX_DIM + int'(in_word.col_index));
  assign elem    = ELEMENT_BITS'(in_word.element_value);

  // read addresses walk row of A and column of B
  assign rd_en     = (state == ST_RUN);
  assign a_rd_addr = AW'(int'(q_row) * MAX_DIM + int'(k));
  assign b_rd_addr = AW'(int'(k) * MAX_DIM + int'(q_col));

  imm_store #(.DEPTH(DEPTH), .AW(AW), .W(ELEMENT_BITS)) u_store_a (
    .clk     (clk),
    .wr_en   (a_wr),
    .wr_addr (wr_addr),
    .wr_data (elem),
    .rd_en   (rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_data)
  );

  imm_store #(.DEPTH(DEPTH), .AW(AW), .W(ELEMENT_BITS)) u_store_b (
    .clk     (clk),
    .wr_en   (b_wr),
    .wr_addr (wr_addr),
    .wr_data (elem),
    .rd_en   (rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_data)
  );

  // multiply-accumulate over the returned pairs
  assign mac_ctl.clear = is_query;
  assign mac_ctl.valid = rd_v;

  imm_mac #(.ELEMENT_BITS(ELEMENT_BITS)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (a_data),
    .b    (b_data),
    .acc  (acc),
    .busy (mac_busy)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_query) state_next = query_err ? ST_FINISH : ST_RUN;
      end
      ST_RUN: begin
        if (k == inner_dimension - imm_pkg::CFG_BITS'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v && !mac_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= rd_en;
    end
  end

  // query context and inner counter
  always_ff @(posedge clk) begin
    if (is_query) begin
      q_row <= in_word.row_index;
      q_col <= in_word.col_index;
      q_err <= query_err;
      k     <= '0;
    end else if (state == ST_RUN) begin
      k <= k + imm_pkg::CFG_BITS'(1);
    end
  end

  // output register
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_word.product_value <= q_err ? '0 : acc;
      out_word.index_error   <= q_err;
    end
  end

  // an error word never carries a sum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.index_error |-> out_word.product_value == '0)
    else $error("error word with nonzero product");

  // no read in flight while the input is open
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !rd_v && !mac_busy)
    else $error("read pending while idle");

  // read data only follows a walk cycle
  a_read_origin: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state == ST_RUN))
    else $error("read data without issue");

  // a finished query reaches the output register
  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && (!out_valid || out_ready) |=> out_valid && state == ST_IDLE)
    else $error("finished query not delivered");

endmodule

@@ rtl/imm_store.sv @@
module imm_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int W     = 16
) (
  input  logic         clk,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic         rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/imm_mac.sv @@
module imm_mac #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  imm_pkg::imm_mac_ctl_t               ctl,
  input  logic signed [ELEMENT_BITS-1:0]      a,
  input  logic signed [ELEMENT_BITS-1:0]      b,
  output logic [imm_pkg::PRODUCT_BITS-1:0]    acc,
  output logic                                busy
);

  localparam int PW   = 2 * ELEMENT_BITS;
  localparam int WIDE = (PW > imm_pkg::PRODUCT_BITS) ? PW : imm_pkg::PRODUCT_BITS;

  logic signed [PW-1:0]   prod;
  logic                   prod_v;
  logic signed [WIDE-1:0] prod_ext;

  // sign extend the product, wrap to the result width
  assign prod_ext = WIDE'(prod);
  assign busy     = prod_v;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.valid;
    end
    if (ctl.valid) begin
      prod <= a * b;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + prod_ext[imm_pkg::PRODUCT_BITS-1:0];
    end
  end

endmodule

@@ dv/integer_matrix_multiply_test.sv @@
`timescale 1ns / 100ps

module integer_matrix_multiply_test;
  import imm_pkg::*;

  // codes the package leaves unnamed
  localparam logic [MODE_BITS-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE   = 2'd3;

  localparam int DIM           = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int REPORT_LIMIT  = 10;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  imm_in_t                 in_word;
  logic                    out_valid;
  logic                    out_ready;
  imm_out_t                out_word;
  logic                    cfg_write_en;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  // shadow copy of the matrices and the dimension registers
  logic signed [IN_ELEM_BITS-1:0] a_store [DIM*DIM];
  logic signed [IN_ELEM_BITS-1:0] b_store [DIM*DIM];
  bit                             a_written [DIM*DIM];
  bit                             b_written [DIM*DIM];
  int                             dim_rows;
  int                             dim_inner;
  int                             dim_cols;

  imm_out_t pending_products [$];
  imm_out_t want_word;

  int sender_idle_pct;
  int receiver_idle_pct;
  int words_sent;
  int queries_sent;
  int products_checked;
  int index_errors_seen;
  int settings_done;
  int mismatch_count;
  int failures;

  integer_matrix_multiply i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_word),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("timeout: %0d products still pending", pending_products.size());
    $display("** integer_matrix_multiply: FAILED **");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // dimension register clamp: zero reads as one, large values as the maximum
  function automatic int clamp_dim(logic [CFG_BITS-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM) return DIM;
    return int'(raw);
  endfunction

  // dot product of row of a and column of b over the inner dimension
  function automatic imm_out_t predict_product(int row, int col);
    imm_out_t           res;
    logic signed [47:0] acc;
    logic signed [31:0] prod;
    acc = '0;
    res.index_error = 1'b0;
    if (row >= dim_rows || col >= dim_cols) begin
      res.index_error = 1'b1;
    end else begin
      for (int k = 0; k < dim_inner; k++) begin
        prod = a_store[row*DIM+k] * b_store[k*DIM+col];
        acc = acc + prod;
      end
    end
    res.product_value = acc;
    return res;
  endfunction

  // update the shadow state for an accepted word
  function automatic void absorb_word(imm_in_t w);
    int row;
    int col;
    row = int'(w.row_index);
    col = int'(w.col_index);
    case (w.mode)
      MODE_WRITE_A: begin
        if (row < dim_rows && col < dim_inner) begin
          a_store[row*DIM+col] = w.element_value;
          a_written[row*DIM+col] = 1'b1;
        end
      end
      MODE_WRITE_B: begin
        if (row < dim_inner && col < dim_cols) begin
          b_store[row*DIM+col] = w.element_value;
          b_written[row*DIM+col] = 1'b1;
        end
      end
      MODE_QUERY: begin
        pending_products.push_back(predict_product(row, col));
        queries_sent++;
      end
      default: ;
    endcase
    words_sent++;
  endfunction

  function automatic imm_in_t make_word(logic [MODE_BITS-1:0] mode, int row, int col,
                                        logic [IN_ELEM_BITS-1:0] value);
    imm_in_t w;
    w.mode          = mode;
    w.row_index     = INDEX_BITS'(row);
    w.col_index     = INDEX_BITS'(col);
    w.element_value = value;
    return w;
  endfunction

  // element values lean toward the extremes
  function automatic logic [IN_ELEM_BITS-1:0] pick_element();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return IN_ELEM_BITS'($urandom);
    endcase
  endfunction

  // drive one word, with random idle cycles ahead of it
  task automatic send_word(imm_in_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    absorb_word(w);
  endtask

  // query one product element, writing any operand not yet stored
  task automatic send_query(int row, int col);
    if (row < dim_rows && col < dim_cols) begin
      for (int k = 0; k < dim_inner; k++) begin
        if (!a_written[row*DIM+k])
          send_word(make_word(MODE_WRITE_A, row, k, pick_element()));
        if (!b_written[k*DIM+col])
          send_word(make_word(MODE_WRITE_B, k, col, pick_element()));
      end
    end
    send_word(make_word(MODE_QUERY, row, col, pick_element()));
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    case (idx)
      REG_ROWS_OF_A:       dim_rows  = clamp_dim(data);
      REG_INNER_DIMENSION: dim_inner = clamp_dim(data);
      REG_COLS_OF_B:       dim_cols  = clamp_dim(data);
      default: ;
    endcase
  endtask

  // reprogram the dimensions once the engine has gone quiet
  task automatic write_dims(logic [CFG_BITS-1:0] rows, logic [CFG_BITS-1:0] inner,
                            logic [CFG_BITS-1:0] cols, bit poke_spare);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_ROWS_OF_A, rows);
    write_register(REG_INNER_DIMENSION, inner);
    write_register(REG_COLS_OF_B, cols);
    if (poke_spare)
      write_register(REG_SPARE, CFG_BITS'($urandom));
    @(negedge clk);
    cfg_write_en <= 1'b0;
    settings_done++;
  endtask

  // one-by-one matrices with the largest magnitudes
  task automatic test_single_element_extremes();
    write_dims(5'd1, 5'd1, 5'd1, 1'b0);
    send_word(make_word(MODE_WRITE_A, 0, 0, 16'h8000));
    send_word(make_word(MODE_WRITE_B, 0, 0, 16'h8000));
    send_query(0, 0);
    send_word(make_word(MODE_WRITE_A, 0, 0, 16'h7fff));
    send_query(0, 0);
    send_word(make_word(MODE_WRITE_B, 0, 0, 16'h7fff));
    send_query(0, 0);
    send_word(make_word(MODE_WRITE_A, 0, 0, 16'h0000));
    send_query(0, 0);
  endtask

  // writes outside the dimensions and the unused mode leave the matrices alone
  task automatic test_ignored_words();
    send_word(make_word(MODE_WRITE_A, 0, 0, 16'hffff));
    send_word(make_word(MODE_WRITE_A, 0, 1, 16'h1234));
    send_word(make_word(MODE_WRITE_A, 1, 0, 16'h4321));
    send_word(make_word(MODE_WRITE_B, 1, 0, 16'h5555));
    send_word(make_word(MODE_WRITE_B, 0, 1, 16'haaaa));
    send_word(make_word(MODE_UNUSED, 0, 0, 16'h0005));
    send_word(make_word(MODE_UNUSED, 15, 15, 16'hffff));
    send_query(0, 0);
  endtask

  // queries past the product dimensions
  task automatic test_index_errors();
    send_query(1, 0);
    send_query(0, 1);
    send_query(15, 15);
  endtask

  // zero and oversized register values, the spare index, full size
  task automatic test_register_limits();
    write_dims(5'd0, 5'd31, 5'd17, 1'b1);
    send_query(0, 15);
    send_query(0, 0);
    send_query(1, 0);
    write_dims(5'd16, 5'd16, 5'd16, 1'b0);
    send_query(15, 15);
    send_query(15, 0);
  endtask

  // random mix of writes and queries under one idling pattern
  task automatic test_random_traffic(int sender_pct, int receiver_pct, int words);
    int stop_at;
    int next_cfg;
    int round;
    int sel;
    int pick;
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
    stop_at  = words_sent + words;
    next_cfg = words_sent;
    round    = 0;
    while (words_sent < stop_at) begin
      // new dimensions after each fifty or more words, extremes first
      if (words_sent >= next_cfg) begin
        sel = (round < 2) ? round : $urandom_range(0, 3);
        case (sel)
          0:       write_dims(5'd16, 5'd16, 5'd16, 1'($urandom_range(0, 1)));
          1:       write_dims(5'd1, 5'd1, 5'd1, 1'($urandom_range(0, 1)));
          default: write_dims(CFG_BITS'($urandom_range(0, 31)),
                              CFG_BITS'($urandom_range(0, 31)),
                              CFG_BITS'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
        endcase
        round++;
        next_cfg = words_sent + 50;
      end
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        send_word(make_word(MODE_WRITE_A, $urandom_range(0, dim_rows - 1),
                            $urandom_range(0, dim_inner - 1), pick_element()));
      end else if (pick < 70) begin
        send_word(make_word(MODE_WRITE_B, $urandom_range(0, dim_inner - 1),
                            $urandom_range(0, dim_cols - 1), pick_element()));
      end else if (pick < 92) begin
        // mostly in range, now and then anywhere
        if ($urandom_range(0, 99) < 15)
          send_query($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1));
        else
          send_query($urandom_range(0, dim_rows - 1), $urandom_range(0, dim_cols - 1));
      end else begin
        // noise: unused mode or writes anywhere
        case ($urandom_range(0, 2))
          0: send_word(make_word(MODE_UNUSED, $urandom_range(0, DIM - 1),
                                 $urandom_range(0, DIM - 1), pick_element()));
          1: send_word(make_word(MODE_WRITE_A, $urandom_range(0, DIM - 1),
                                 $urandom_range(0, DIM - 1), pick_element()));
          default: send_word(make_word(MODE_WRITE_B, $urandom_range(0, DIM - 1),
                                       $urandom_range(0, DIM - 1), pick_element()));
        endcase
      end
    end
  endtask

  // compare each result word with the oldest predicted product
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result word: value %0d error %0b",
                   out_word.product_value, out_word.index_error);
        mismatch_count++;
      end else begin
        want_word = pending_products.pop_front();
        products_checked++;
        if (want_word.index_error) index_errors_seen++;
        if (out_word.product_value !== want_word.product_value ||
            out_word.index_error !== want_word.index_error) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("product %0d mismatch: expected value %0d error %0b, got value %0d error %0b",
                     products_checked, want_word.product_value, want_word.index_error,
                     out_word.product_value, out_word.index_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_word      = '0;
    out_ready    = 1'b0;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    dim_rows     = DIM;
    dim_inner    = DIM;
    dim_cols     = DIM;
    foreach (a_written[i]) begin
      a_written[i] = 1'b0;
      b_written[i] = 1'b0;
    end
    sender_idle_pct   = 14;
    receiver_idle_pct = 80;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_element_extremes();
    test_ignored_words();
    test_index_errors();
    test_register_limits();
    test_random_traffic(14, 80, 120);
    test_random_traffic(80, 14, 120);
    test_random_traffic(0, 0, 120);

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    failures = mismatch_count + pending_products.size();
    $display("sent %0d words (%0d queries) over %0d dimension settings",
             words_sent, queries_sent, settings_done);
    $display("checked %0d products, %0d of them index errors, %0d mismatches",
             products_checked, index_errors_seen, mismatch_count);
    if (failures == 0) begin
      $display("** integer_matrix_multiply: PASSED **");
    end else begin
      $display("** integer_matrix_multiply: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/imm_pkg.sv
rtl/imm_store.sv
rtl/imm_mac.sv
rtl/integer_matrix_multiply.sv
dv/integer_matrix_multiply_test.sv
